/* sv/fastcgi_record_deframer_defines.svh */
// ============================================================================
// fastcgi record deframer assertion macros
// shared property shapes for the deframer's concurrent checks
// ============================================================================
`ifndef FASTCGI_RECORD_DEFRAMER_DEFINES_SVH
`define FASTCGI_RECORD_DEFRAMER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define FCGI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("fcgi check failed: same cycle");

// next-cycle implication, disabled while in reset
`define FCGI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("fcgi check failed: next cycle");

`endif

/* sv/fcgi_pkg.sv */
// ============================================================================
// fcgi_pkg
// types and constants shared by the fastcgi record deframer
// ============================================================================
`timescale 1ns / 1ps

package fcgi_pkg;

   // header layout
   localparam logic [2:0] HDR_IDX_TYPE      = 3'd1;
   localparam logic [2:0] HDR_IDX_LEN_HI    = 3'd4;
   localparam logic [2:0] HDR_IDX_LEN_LO    = 3'd5;
   localparam logic [2:0] HDR_IDX_PAD       = 3'd6;
   localparam logic [2:0] HDR_IDX_LAST      = 3'd7;

   // record type codes on the wire
   localparam logic [7:0] TYPE_END_REQUEST  = 8'd3;
   localparam logic [7:0] TYPE_STDOUT       = 8'd6;
   localparam logic [7:0] TYPE_STDERR       = 8'd7;

   // record kind codes on the response
   localparam logic [1:0] KIND_STDOUT       = 2'd0;
   localparam logic [1:0] KIND_STDERR       = 2'd1;
   localparam logic [1:0] KIND_END_REQUEST  = 2'd2;

   // parser phases
   localparam logic [1:0] PH_HEADER         = 2'd0;
   localparam logic [1:0] PH_CONTENT        = 2'd1;
   localparam logic [1:0] PH_PADDING        = 2'd2;
   localparam logic [1:0] PH_HALTED         = 2'd3;

   typedef struct packed {
      logic [7:0] payload_byte;
      logic [1:0] record_kind;
      logic       record_last;
      logic       request_end;
      logic       framing_error;
   } fcgi_rsp_type;

   typedef struct packed {
      logic         valid;
      fcgi_rsp_type data;
   } fcgi_step_type;

endpackage

/* sv/fcgi_if.sv */
// ============================================================================
// fcgi channel interfaces
// valid/ready channels for raw request bytes and deframed response items
// ============================================================================
`timescale 1ns / 1ps

interface fcgi_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;

   modport source (output valid, output in_byte, input ready);
   modport sink   (input valid, input in_byte, output ready);
endinterface

interface fcgi_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] payload_byte;
   logic [1:0] record_kind;
   logic       record_last;
   logic       request_end;
   logic       framing_error;

   modport source (output valid, output payload_byte, output record_kind,
                   output record_last, output request_end, output framing_error,
                   input ready);
   modport sink   (input valid, input payload_byte, input record_kind,
                   input record_last, input request_end, input framing_error,
                   output ready);
endinterface

/* sv/fcgi_parser.sv */
// ============================================================================
// fcgi_parser
// record state machine: header capture, content tagging, halt on unknown type, padding skip
// ============================================================================
`timescale 1ns / 1ps
`include "fastcgi_record_deframer_defines.svh"

module fcgi_parser
   import fcgi_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          accept,
   input  logic [7:0]    in_byte,
   output fcgi_step_type step
);

   logic [1:0]  phase_ff,        phase_in;
   logic [2:0]  header_count_ff, header_count_in;
   logic [7:0]  kind_reg_ff,     kind_reg_in;
   logic [15:0] content_left_ff, content_left_in;
   logic [7:0]  padding_left_ff, padding_left_in;
   logic        end_seen_ff,     end_seen_in;

   logic [15:0] content_dec;
   logic [7:0]  padding_dec;
   logic        type_known;

   assign content_dec = content_left_ff - 16'd1;
   assign padding_dec = (padding_left_ff != 8'd0) ? padding_left_ff - 8'd1 : 8'd0;
   assign type_known  = kind_reg_ff inside {TYPE_END_REQUEST, TYPE_STDOUT, TYPE_STDERR};

   always_comb begin
      phase_in        = phase_ff;
      header_count_in = header_count_ff;
      kind_reg_in     = kind_reg_ff;
      content_left_in = content_left_ff;
      padding_left_in = padding_left_ff;
      end_seen_in     = end_seen_ff;
      step            = '0;

      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               case (header_count_ff)
                  HDR_IDX_TYPE:   kind_reg_in           = in_byte;
                  HDR_IDX_LEN_HI: content_left_in[15:8] = in_byte;
                  HDR_IDX_LEN_LO: content_left_in[7:0]  = in_byte;
                  HDR_IDX_PAD:    padding_left_in       = in_byte;
                  default: ;
               endcase
               if (header_count_ff != HDR_IDX_LAST) begin
                  header_count_in = header_count_ff + 3'd1;
               end else begin
                  header_count_in = 3'd0;
                  if (content_left_ff == 16'd0) begin
                     // empty record, no result whatever its type
                     phase_in = (padding_left_ff != 8'd0) ? PH_PADDING : PH_HEADER;
                  end else if (!type_known) begin
                     phase_in                = PH_HALTED;
                     step.valid              = 1'b1;
                     step.data.request_end   = end_seen_ff;
                     step.data.framing_error = 1'b1;
                  end else begin
                     phase_in = PH_CONTENT;
                  end
               end
            end
            PH_CONTENT: begin
               step.valid             = 1'b1;
               step.data.payload_byte = in_byte;
               if (kind_reg_ff == TYPE_STDOUT) begin
                  step.data.record_kind = KIND_STDOUT;
               end else if (kind_reg_ff == TYPE_STDERR) begin
                  step.data.record_kind = KIND_STDERR;
               end else begin
                  step.data.record_kind = KIND_END_REQUEST;
                  end_seen_in           = 1'b1;
               end
               step.data.request_end = end_seen_in;
               step.data.record_last = (content_dec == 16'd0);
               content_left_in       = content_dec;
               if (content_dec == 16'd0) begin
                  phase_in        = (padding_left_ff != 8'd0) ? PH_PADDING : PH_HEADER;
                  header_count_in = 3'd0;
               end
            end
            PH_PADDING: begin
               padding_left_in = padding_dec;
               if (padding_dec == 8'd0) begin
                  phase_in        = PH_HEADER;
                  header_count_in = 3'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         header_count_ff <= 3'd0;
         kind_reg_ff     <= 8'd0;
         content_left_ff <= 16'd0;
         padding_left_ff <= 8'd0;
         end_seen_ff     <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         header_count_ff <= header_count_in;
         kind_reg_ff     <= kind_reg_in;
         content_left_ff <= content_left_in;
         padding_left_ff <= padding_left_in;
         end_seen_ff     <= end_seen_in;
      end
   end

   // halted is sticky until reset
   `FCGI_ASSERT_NEXT(a_halt_sticky, clock, reset, phase_ff == PH_HALTED, phase_ff == PH_HALTED)
   // content phase always has bytes left to pass on
   `FCGI_ASSERT_NOW(a_content_nonzero, clock, reset, phase_ff == PH_CONTENT, content_left_ff != 16'd0)
   // header byte counting only happens in the header phase
   `FCGI_ASSERT_NOW(a_count_in_header, clock, reset, header_count_ff != 3'd0, phase_ff == PH_HEADER)
   // a framing error always moves the parser to halted
   `FCGI_ASSERT_NEXT(a_error_halts, clock, reset, step.valid && step.data.framing_error, phase_ff == PH_HALTED)

endmodule

/* sv/fastcgi_record_deframer.sv */
// ============================================================================
// fastcgi_record_deframer
// receive-side fastcgi record deframer, absent response back-pressure one byte per clock
// ============================================================================
// Takes the byte stream returned by a fastcgi application, one byte per
// request, and gathers each 8-byte record header (type, 16-bit big-endian
// content length, padding length). Every content byte of a stdout, stderr or
// end-request record comes out as one response tagged with its kind, with
// record_last on the final content byte and request_end once end-request
// content has been seen. Padding and empty records give no response. A record
// with nonzero content and an unknown type gives a single framing_error
// response, after which all bytes are dropped until reset. Throughput is one
// request per clock: the parser updates its state in the cycle a byte is taken,
// and a single response register holds the result; a new byte is taken whenever
// that register is empty or is being emptied in the same cycle, so the only
// stall comes from back-pressure on the response side. A response appears in the
// cycle after its byte is taken.
`timescale 1ns / 1ps

module fastcgi_record_deframer
   import fcgi_pkg::*;
(
   input logic       clock,
   input logic       reset,
   fcgi_req_if.sink  req_if,
   fcgi_rsp_if.source rsp_if
);

   fcgi_step_type step;
   logic          req_accept;

   // response register, payload carries no reset
   logic          rsp_valid_ff, rsp_valid_in;
   fcgi_rsp_type  rsp_data_ff,  rsp_data_in;

   // take a byte whenever the response slot is free or draining now
   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_accept   = req_if.valid && req_if.ready;

   fcgi_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .accept  (req_accept),
      .in_byte (req_if.in_byte),
      .step    (step)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      // a fresh result replaces one being drained in the same cycle
      if (step.valid) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = step.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.payload_byte  = rsp_data_ff.payload_byte;
   assign rsp_if.record_kind   = rsp_data_ff.record_kind;
   assign rsp_if.record_last   = rsp_data_ff.record_last;
   assign rsp_if.request_end   = rsp_data_ff.request_end;
   assign rsp_if.framing_error = rsp_data_ff.framing_error;

endmodule
